FILE: rtl/rpft_pkg.sv
// Shared types, register indexes and fixed-point helpers for the rigid pose frame transform.
package rpft_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned QUAT_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic signed [POS_W-1:0]    pos_t;
    typedef logic signed [QUAT_W-1:0]   quat_t;
    typedef logic signed [2*QUAT_W-1:0] qprod_t;
    typedef logic signed [2*QUAT_W+1:0] qsum_t;
    typedef logic signed [2*POS_W-1:0]  wide_t;
    typedef logic [STAMP_W-1:0]         stamp_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_MOUNT_QX    = 3'd0;
    localparam cfg_idx_t CFG_MOUNT_QY    = 3'd1;
    localparam cfg_idx_t CFG_MOUNT_QZ    = 3'd2;
    localparam cfg_idx_t CFG_MOUNT_QW    = 3'd3;
    localparam cfg_idx_t CFG_MOUNT_OFF_X = 3'd4;
    localparam cfg_idx_t CFG_MOUNT_OFF_Y = 3'd5;
    localparam cfg_idx_t CFG_MOUNT_OFF_Z = 3'd6;

    localparam quat_t Q14_ONE     = 16'sd16384;
    localparam quat_t Q14_NEG_ONE = -16'sd16384;
    localparam logic signed [33:0] Q28_ONE = 34'sd268435456;

    // Clamp a Q1.14 component to [-1, +1].
    function automatic quat_t clamp_q14(input quat_t v);
        quat_t r;
        if (v > Q14_ONE) begin
            r = Q14_ONE;
        end else if (v < Q14_NEG_ONE) begin
            r = Q14_NEG_ONE;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Difference of two Q15.16 values, saturated to 32 bits.
    function automatic pos_t sub_sat32(input pos_t a, input pos_t b);
        logic signed [POS_W:0] d;
        pos_t r;
        d = 33'(a) - 33'(b);
        if (d[POS_W] != d[POS_W-1]) begin
            r = d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = d[POS_W-1:0];
        end
        return r;
    endfunction

    // Q2.28 sum to Q1.14, round half up, clamp to [-1, +1].
    function automatic quat_t rnd_sat_q14(input qsum_t v);
        logic signed [34:0] t;
        logic signed [20:0] s;
        quat_t r;
        t = 35'(v) + 35'sd8192;
        s = 21'(t >>> 14);
        if (s > 21'sd16384) begin
            r = Q14_ONE;
        end else if (s < -21'sd16384) begin
            r = Q14_NEG_ONE;
        end else begin
            r = s[QUAT_W-1:0];
        end
        return r;
    endfunction

    // Q.44 sum to Q15.16, round half up, saturate to 32 bits.
    function automatic pos_t rnd_sat32(input wide_t v);
        wide_t t;
        logic signed [35:0] s;
        pos_t r;
        t = v + 64'sd134217728;
        s = 36'(t >>> 28);
        if (s > 36'sd2147483647) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else if (s < -36'sd2147483648) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = s[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/rigid_pose_frame_transform.sv
// Top level of the rigid pose frame transform: camera-frame tag pose to body frame.
//
//  Channel   Direction  Handshake             Words carried
//  s_        in         s_valid / s_ready     tag_count, pos_x..z, rot_x..w, stamp
//  m_        out        m_valid / m_ready     body_pos_x..z, body_rot_x..w, out_stamp
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (mount quaternion, offset)
//
// One word can enter every cycle unless back-pressure from m_ready stalls the pipeline;
// the depth from input acceptance to the m_ channel is set by the rotation path: a
// stage of 16x16 products, a stage forming the rotation matrix, a stage of 32x32
// products, a stage summing them and the rounding/saturating output register.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity mount
// with zero offset. Each stage holds its word while the stage after it is full and
// stalled, so back-pressure on m_ready ripples back to s_ready without losing a word.
// Words whose tag_count is not exactly one are accepted and dropped at the input.
module rigid_pose_frame_transform
    import rpft_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COUNT_W-1:0]    s_tag_count,
    input  pos_t                  s_pos_x,
    input  pos_t                  s_pos_y,
    input  pos_t                  s_pos_z,
    input  quat_t                 s_rot_x,
    input  quat_t                 s_rot_y,
    input  quat_t                 s_rot_z,
    input  quat_t                 s_rot_w,
    input  stamp_t                s_stamp,

    output logic                  m_valid,
    input  logic                  m_ready,
    output pos_t                  m_body_pos_x,
    output pos_t                  m_body_pos_y,
    output pos_t                  m_body_pos_z,
    output quat_t                 m_body_rot_x,
    output quat_t                 m_body_rot_y,
    output quat_t                 m_body_rot_z,
    output quat_t                 m_body_rot_w,
    output stamp_t                m_out_stamp,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    quat_t mqx_reg, mqy_reg, mqz_reg, mqw_reg;
    pos_t  offx_reg, offy_reg, offz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mqx_reg  <= '0;
            mqy_reg  <= '0;
            mqz_reg  <= '0;
            mqw_reg  <= Q14_ONE;
            offx_reg <= '0;
            offy_reg <= '0;
            offz_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MOUNT_QX:    mqx_reg  <= cfg_data[QUAT_W-1:0];
                CFG_MOUNT_QY:    mqy_reg  <= cfg_data[QUAT_W-1:0];
                CFG_MOUNT_QZ:    mqz_reg  <= cfg_data[QUAT_W-1:0];
                CFG_MOUNT_QW:    mqw_reg  <= cfg_data[QUAT_W-1:0];
                CFG_MOUNT_OFF_X: offx_reg <= cfg_data;
                CFG_MOUNT_OFF_Y: offy_reg <= cfg_data;
                CFG_MOUNT_OFF_Z: offz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves on.
    logic en1, en2, en3, en4, en5;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, out_vld_reg;

    assign en5 = !out_vld_reg || m_ready;
    assign en4 = !s4_vld_reg || en5;
    assign en3 = !s3_vld_reg || en4;
    assign en2 = !s2_vld_reg || en3;
    assign en1 = !s1_vld_reg || en2;

    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (en1) begin
                s1_vld_reg <= s_valid && (s_tag_count == COUNT_W'(1));
            end
            if (en2) begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (en3) begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en4) begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (en5) begin
                out_vld_reg <= s4_vld_reg;
            end
        end
    end

    // Stage 1: clamp the mount, form all 16x16 products and the offset difference.
    quat_t  mx, my, mz, mw;
    qprod_t s1_mm_reg [3][3];    // rows hold mount products xx xy xz, xw yy yz and yw zw zz
    qprod_t s1_hp_reg [4][4];    // Hamilton product terms, rows x, y, z, w
    pos_t   s1_d_reg  [3];
    stamp_t s1_stamp_reg;

    assign mx = clamp_q14(mqx_reg);
    assign my = clamp_q14(mqy_reg);
    assign mz = clamp_q14(mqz_reg);
    assign mw = clamp_q14(mqw_reg);

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_mm_reg[0][0] <= mx * mx;
            s1_mm_reg[0][1] <= mx * my;
            s1_mm_reg[0][2] <= mx * mz;
            s1_mm_reg[1][0] <= mx * mw;
            s1_mm_reg[1][1] <= my * my;
            s1_mm_reg[1][2] <= my * mz;
            s1_mm_reg[2][0] <= my * mw;
            s1_mm_reg[2][1] <= mz * mw;
            s1_mm_reg[2][2] <= mz * mz;

            // Each row sums as t0 + t1 + t2 - t3, except w: t0 - t1 - t2 - t3.
            s1_hp_reg[0][0] <= s_rot_w * mx;
            s1_hp_reg[0][1] <= s_rot_x * mw;
            s1_hp_reg[0][2] <= s_rot_y * mz;
            s1_hp_reg[0][3] <= s_rot_z * my;
            s1_hp_reg[1][0] <= s_rot_w * my;
            s1_hp_reg[1][1] <= s_rot_y * mw;
            s1_hp_reg[1][2] <= s_rot_z * mx;
            s1_hp_reg[1][3] <= s_rot_x * mz;
            s1_hp_reg[2][0] <= s_rot_w * mz;
            s1_hp_reg[2][1] <= s_rot_z * mw;
            s1_hp_reg[2][2] <= s_rot_x * my;
            s1_hp_reg[2][3] <= s_rot_y * mx;
            s1_hp_reg[3][0] <= s_rot_w * mw;
            s1_hp_reg[3][1] <= s_rot_x * mx;
            s1_hp_reg[3][2] <= s_rot_y * my;
            s1_hp_reg[3][3] <= s_rot_z * mz;

            s1_d_reg[0]  <= sub_sat32(s_pos_x, offx_reg);
            s1_d_reg[1]  <= sub_sat32(s_pos_y, offy_reg);
            s1_d_reg[2]  <= sub_sat32(s_pos_z, offz_reg);
            s1_stamp_reg <= s_stamp;
        end
    end

    // Stage 2: rotation matrix in Q.28 and the Hamilton sums in Q2.28.
    // The matrix is stored transposed (rt[i][j] = r[j][i]) so that row i
    // yields body component i.
    logic signed [33:0] xx, yy, zz, xy, xz, xw, yz, yw, zw;
    pos_t   s2_rt_reg [3][3];
    qsum_t  s2_q_reg  [4];
    pos_t   s2_d_reg  [3];
    stamp_t s2_stamp_reg;

    assign xx = 34'(s1_mm_reg[0][0]);
    assign xy = 34'(s1_mm_reg[0][1]);
    assign xz = 34'(s1_mm_reg[0][2]);
    assign xw = 34'(s1_mm_reg[1][0]);
    assign yy = 34'(s1_mm_reg[1][1]);
    assign yz = 34'(s1_mm_reg[1][2]);
    assign yw = 34'(s1_mm_reg[2][0]);
    assign zw = 34'(s1_mm_reg[2][1]);
    assign zz = 34'(s1_mm_reg[2][2]);

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_rt_reg[0][0] <= 32'(Q28_ONE - ((yy + zz) <<< 1));
            s2_rt_reg[0][1] <= 32'((xy + zw) <<< 1);
            s2_rt_reg[0][2] <= 32'((xz - yw) <<< 1);
            s2_rt_reg[1][0] <= 32'((xy - zw) <<< 1);
            s2_rt_reg[1][1] <= 32'(Q28_ONE - ((xx + zz) <<< 1));
            s2_rt_reg[1][2] <= 32'((yz + xw) <<< 1);
            s2_rt_reg[2][0] <= 32'((xz + yw) <<< 1);
            s2_rt_reg[2][1] <= 32'((yz - xw) <<< 1);
            s2_rt_reg[2][2] <= 32'(Q28_ONE - ((xx + yy) <<< 1));

            for (int i = 0; i < 3; i++) begin
                s2_q_reg[i] <= 34'(s1_hp_reg[i][0]) + 34'(s1_hp_reg[i][1])
                             + 34'(s1_hp_reg[i][2]) - 34'(s1_hp_reg[i][3]);
            end
            s2_q_reg[3] <= 34'(s1_hp_reg[3][0]) - 34'(s1_hp_reg[3][1])
                         - 34'(s1_hp_reg[3][2]) - 34'(s1_hp_reg[3][3]);

            s2_d_reg     <= s1_d_reg;
            s2_stamp_reg <= s1_stamp_reg;
        end
    end

    // Stage 3: 32x32 products of the transposed matrix with the offset-corrected
    // position; the orientation is rounded and clamped here.
    wide_t  s3_p_reg [3][3];
    quat_t  s3_q_reg [4];
    stamp_t s3_stamp_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    s3_p_reg[i][j] <= wide_t'(s2_rt_reg[i][j]) * wide_t'(s2_d_reg[j]);
                end
            end
            for (int k = 0; k < 4; k++) begin
                s3_q_reg[k] <= rnd_sat_q14(s2_q_reg[k]);
            end
            s3_stamp_reg <= s2_stamp_reg;
        end
    end

    // Stage 4: sum each row of products. Magnitudes stay below 2^63.
    wide_t  s4_b_reg [3];
    quat_t  s4_q_reg [4];
    stamp_t s4_stamp_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                s4_b_reg[i] <= s3_p_reg[i][0] + s3_p_reg[i][1] + s3_p_reg[i][2];
            end
            s4_q_reg     <= s3_q_reg;
            s4_stamp_reg <= s3_stamp_reg;
        end
    end

    // Output register: round to Q15.16 and saturate.
    pos_t   out_pos_reg [3];
    quat_t  out_q_reg   [4];
    stamp_t out_stamp_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            for (int i = 0; i < 3; i++) begin
                out_pos_reg[i] <= rnd_sat32(s4_b_reg[i]);
            end
            out_q_reg     <= s4_q_reg;
            out_stamp_reg <= s4_stamp_reg;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_body_pos_x = out_pos_reg[0];
    assign m_body_pos_y = out_pos_reg[1];
    assign m_body_pos_z = out_pos_reg[2];
    assign m_body_rot_x = out_q_reg[0];
    assign m_body_rot_y = out_q_reg[1];
    assign m_body_rot_z = out_q_reg[2];
    assign m_body_rot_w = out_q_reg[3];
    assign m_out_stamp  = out_stamp_reg;

endmodule

FILE: rtl/rpft_checker.sv
// Port-level checker for the rigid pose frame transform and its bind statement.
module rpft_checker
    import rpft_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input pos_t                  m_body_pos_x,
    input pos_t                  m_body_pos_y,
    input pos_t                  m_body_pos_z,
    input quat_t                 m_body_rot_x,
    input quat_t                 m_body_rot_y,
    input quat_t                 m_body_rot_z,
    input quat_t                 m_body_rot_w,
    input stamp_t                m_out_stamp,
    input logic                  cfg_ready
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_body_pos_x) && $stable(m_body_pos_y)
            && $stable(m_body_pos_z) && $stable(m_body_rot_x) && $stable(m_body_rot_y)
            && $stable(m_body_rot_z) && $stable(m_body_rot_w) && $stable(m_out_stamp))
        else $error("result word changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // Composed quaternion components stay within [-1, +1] in Q1.14.
    a_rot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_body_rot_x <= Q14_ONE && m_body_rot_x >= Q14_NEG_ONE
            && m_body_rot_y <= Q14_ONE && m_body_rot_y >= Q14_NEG_ONE
            && m_body_rot_z <= Q14_ONE && m_body_rot_z >= Q14_NEG_ONE
            && m_body_rot_w <= Q14_ONE && m_body_rot_w >= Q14_NEG_ONE)
        else $error("composed quaternion out of range");

    // An empty output stage always lets the input side move.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!m_valid) && $past(!m_valid, 2) && $past(!m_valid, 3)
            && $past(!m_valid, 4) && $past(aresetn, 4) |-> s_ready && cfg_ready)
        else $error("input stalled with an empty pipeline");

endmodule

bind rigid_pose_frame_transform rpft_checker u_rpft_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of rigid_pose_frame_transform: predicts each body-frame pose and checks the block.
module tb_top;
    import rpft_pkg::*;

    // Cycles allowed after the last expected word before a register write or the verdict.
    // Dropped detections may still be in flight in the block's pipeline.
    localparam int SETTLE_CYCLES   = 10;
    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT     = 2000;
    localparam int ROUNDS          = 6;
    localparam int POSES_PER_ROUND = 110;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int BURST_WORDS     = 40;
    localparam int REPORT_LIMIT    = 10;

    localparam pos_t  POS_MOST   = 32'sh7FFF_FFFF;
    localparam pos_t  POS_LEAST  = 32'sh8000_0000;
    localparam quat_t QUAT_MOST  = 16'sh7FFF;
    localparam quat_t QUAT_LEAST = 16'sh8000;

    // Wide forms of the saturation bounds, used by the predictor.
    localparam longint WIDE_POS_MAX = 64'sd2147483647;
    localparam longint WIDE_POS_MIN = -64'sd2147483648;
    localparam longint WIDE_Q14_ONE = 64'sd16384;
    localparam longint WIDE_Q28_ONE = 64'sd268435456;

    // One detection word on the s_ channel, in port order.
    typedef struct packed {
        logic [COUNT_W-1:0] tag_count;
        pos_t               pos_x, pos_y, pos_z;
        quat_t              rot_x, rot_y, rot_z, rot_w;
        stamp_t             stamp;
    } pose_word_t;

    // One body-frame pose word on the m_ channel, in port order.
    typedef struct packed {
        pos_t   body_pos_x, body_pos_y, body_pos_z;
        quat_t  body_rot_x, body_rot_y, body_rot_z, body_rot_w;
        stamp_t out_stamp;
    } body_word_t;

    // Keeps its own copy of the mount registers, turns every accepted detection into the
    // body pose it must produce, and matches the block's words against them in order.
    class pose_scoreboard;
        quat_t      mount_qx, mount_qy, mount_qz, mount_qw;
        pos_t       off_x, off_y, off_z;
        body_word_t awaited_poses[$];
        int         failures;

        function new();
            mount_qx = '0;
            mount_qy = '0;
            mount_qz = '0;
            mount_qw = Q14_ONE;
            off_x    = '0;
            off_y    = '0;
            off_z    = '0;
            failures = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Drop s fraction bits, rounding to nearest with halves going up.
        function longint round_off(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function void load_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MOUNT_QX:    mount_qx = data[QUAT_W-1:0];
                CFG_MOUNT_QY:    mount_qy = data[QUAT_W-1:0];
                CFG_MOUNT_QZ:    mount_qz = data[QUAT_W-1:0];
                CFG_MOUNT_QW:    mount_qw = data[QUAT_W-1:0];
                CFG_MOUNT_OFF_X: off_x = data;
                CFG_MOUNT_OFF_Y: off_y = data;
                CFG_MOUNT_OFF_Z: off_z = data;
                default: ;
            endcase
        endfunction

        function body_word_t body_pose_of(pose_word_t w);
            longint mx, my, mz, mw, tx, ty, tz, tw;
            longint hx, hy, hz, hw, dx, dy, dz;
            longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
            longint bx, by, bz;
            body_word_t r;
            // The mount is clamped to [-1, +1]; the tag quaternion is taken as given.
            mx = clip(longint'(mount_qx), -WIDE_Q14_ONE, WIDE_Q14_ONE);
            my = clip(longint'(mount_qy), -WIDE_Q14_ONE, WIDE_Q14_ONE);
            mz = clip(longint'(mount_qz), -WIDE_Q14_ONE, WIDE_Q14_ONE);
            mw = clip(longint'(mount_qw), -WIDE_Q14_ONE, WIDE_Q14_ONE);
            tx = longint'(w.rot_x);
            ty = longint'(w.rot_y);
            tz = longint'(w.rot_z);
            tw = longint'(w.rot_w);

            // Hamilton product tag * mount in Q2.28.
            hw = tw * mw - tx * mx - ty * my - tz * mz;
            hx = tw * mx + tx * mw + ty * mz - tz * my;
            hy = tw * my + ty * mw + tz * mx - tx * mz;
            hz = tw * mz + tz * mw + tx * my - ty * mx;

            // Offset removal saturates before the rotation.
            dx = clip(longint'(w.pos_x) - longint'(off_x), WIDE_POS_MIN, WIDE_POS_MAX);
            dy = clip(longint'(w.pos_y) - longint'(off_y), WIDE_POS_MIN, WIDE_POS_MAX);
            dz = clip(longint'(w.pos_z) - longint'(off_z), WIDE_POS_MIN, WIDE_POS_MAX);

            // Unit-form rotation matrix in Q.28; no normalization of the mount.
            r00 = WIDE_Q28_ONE - 2 * (my * my + mz * mz);
            r01 = 2 * (mx * my - mz * mw);
            r02 = 2 * (mx * mz + my * mw);
            r10 = 2 * (mx * my + mz * mw);
            r11 = WIDE_Q28_ONE - 2 * (mx * mx + mz * mz);
            r12 = 2 * (my * mz - mx * mw);
            r20 = 2 * (mx * mz - my * mw);
            r21 = 2 * (my * mz + mx * mw);
            r22 = WIDE_Q28_ONE - 2 * (mx * mx + my * my);

            // The transpose applies the conjugate rotation.
            bx = r00 * dx + r10 * dy + r20 * dz;
            by = r01 * dx + r11 * dy + r21 * dz;
            bz = r02 * dx + r12 * dy + r22 * dz;
            bx = clip(round_off(bx, 28), WIDE_POS_MIN, WIDE_POS_MAX);
            by = clip(round_off(by, 28), WIDE_POS_MIN, WIDE_POS_MAX);
            bz = clip(round_off(bz, 28), WIDE_POS_MIN, WIDE_POS_MAX);
            hx = clip(round_off(hx, 14), -WIDE_Q14_ONE, WIDE_Q14_ONE);
            hy = clip(round_off(hy, 14), -WIDE_Q14_ONE, WIDE_Q14_ONE);
            hz = clip(round_off(hz, 14), -WIDE_Q14_ONE, WIDE_Q14_ONE);
            hw = clip(round_off(hw, 14), -WIDE_Q14_ONE, WIDE_Q14_ONE);

            r.body_pos_x = bx[POS_W-1:0];
            r.body_pos_y = by[POS_W-1:0];
            r.body_pos_z = bz[POS_W-1:0];
            r.body_rot_x = hx[QUAT_W-1:0];
            r.body_rot_y = hy[QUAT_W-1:0];
            r.body_rot_z = hz[QUAT_W-1:0];
            r.body_rot_w = hw[QUAT_W-1:0];
            r.out_stamp  = w.stamp;
            return r;
        endfunction

        // Only a detection word with exactly one tag produces a pose.
        function void note_detection(pose_word_t w);
            if (w.tag_count == 8'd1) begin
                awaited_poses.push_back(body_pose_of(w));
            end
        endfunction

        function string pose_text(body_word_t p);
            return $sformatf("pos %0d %0d %0d rot %0d %0d %0d %0d stamp %h",
                             p.body_pos_x, p.body_pos_y, p.body_pos_z, p.body_rot_x,
                             p.body_rot_y, p.body_rot_z, p.body_rot_w, p.out_stamp);
        endfunction

        function void check_body_pose(body_word_t got);
            body_word_t want;
            string      bad;
            if (awaited_poses.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected pose word at %0t: %s", $realtime, pose_text(got));
                end
                return;
            end
            want = awaited_poses.pop_front();
            bad = "";
            if (got.body_pos_x !== want.body_pos_x) bad = {bad, " body_pos_x"};
            if (got.body_pos_y !== want.body_pos_y) bad = {bad, " body_pos_y"};
            if (got.body_pos_z !== want.body_pos_z) bad = {bad, " body_pos_z"};
            if (got.body_rot_x !== want.body_rot_x) bad = {bad, " body_rot_x"};
            if (got.body_rot_y !== want.body_rot_y) bad = {bad, " body_rot_y"};
            if (got.body_rot_z !== want.body_rot_z) bad = {bad, " body_rot_z"};
            if (got.body_rot_w !== want.body_rot_w) bad = {bad, " body_rot_w"};
            if (got.out_stamp !== want.out_stamp) bad = {bad, " out_stamp"};
            if (bad != "") begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("pose mismatch at %0t in:%s", $realtime, bad);
                    $display("  expected %s", pose_text(want));
                    $display("  actual   %s", pose_text(got));
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [COUNT_W-1:0]    s_tag_count;
    pos_t                  s_pos_x, s_pos_y, s_pos_z;
    quat_t                 s_rot_x, s_rot_y, s_rot_z, s_rot_w;
    stamp_t                s_stamp;
    logic                  m_valid;
    logic                  m_ready;
    pos_t                  m_body_pos_x, m_body_pos_y, m_body_pos_z;
    quat_t                 m_body_rot_x, m_body_rot_y, m_body_rot_z, m_body_rot_w;
    stamp_t                m_out_stamp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pose_scoreboard sb;

    // Traffic shaping shared by the sender and the receiver. In a steady round neither
    // side idles. While burst_left is nonzero the sender offers words back to back, and a
    // nonzero rx_hold_cycles makes the receiver hold m_ready low for that many cycles.
    bit steady         = 1'b0;
    int burst_left     = 0;
    int rx_hold_cycles = 0;

    always #2 aclk = ~aclk;

    rigid_pose_frame_transform dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_tag_count  (s_tag_count),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_rot_x      (s_rot_x),
        .s_rot_y      (s_rot_y),
        .s_rot_z      (s_rot_z),
        .s_rot_w      (s_rot_w),
        .s_stamp      (s_stamp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_body_pos_x (m_body_pos_x),
        .m_body_pos_y (m_body_pos_y),
        .m_body_pos_z (m_body_pos_z),
        .m_body_rot_x (m_body_rot_x),
        .m_body_rot_y (m_body_rot_y),
        .m_body_rot_z (m_body_rot_z),
        .m_body_rot_w (m_body_rot_w),
        .m_out_stamp  (m_out_stamp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic pose_word_t make_pose(logic [COUNT_W-1:0] count, pos_t px, pos_t py,
                                             pos_t pz, quat_t rx, quat_t ry, quat_t rz,
                                             quat_t rw, stamp_t stamp);
        return {count, px, py, pz, rx, ry, rz, rw, stamp};
    endfunction

    // Positions: full-range values, small and medium magnitudes, and the extremes.
    function automatic pos_t random_position(bit only_extremes);
        int   sel;
        pos_t v;
        sel = only_extremes ? 2 : $urandom_range(0, 4);
        case (sel)
            0: v = pos_t'($urandom());
            1: v = pos_t'($urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000);
            2: begin
                case ($urandom_range(0, 4))
                    0: v = POS_LEAST;
                    1: v = POS_MOST;
                    2: v = -32'sd1;
                    3: v = 32'sd1;
                    default: v = '0;
                endcase
            end
            default: v = pos_t'($urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000);
        endcase
        return v;
    endfunction

    // Quaternion components: mostly within [-1, +1], sometimes any 16-bit value.
    function automatic quat_t random_rotation(bit only_extremes);
        int    sel;
        quat_t v;
        sel = only_extremes ? 1 : $urandom_range(0, 5);
        case (sel)
            0: v = quat_t'($urandom());
            1: begin
                case ($urandom_range(0, 4))
                    0: v = Q14_ONE;
                    1: v = Q14_NEG_ONE;
                    2: v = QUAT_LEAST;
                    3: v = QUAT_MOST;
                    default: v = '0;
                endcase
            end
            default: v = quat_t'($urandom_range(0, 32768) - 16384);
        endcase
        return v;
    endfunction

    // Most words carry exactly one detection; the rest carry an arbitrary count.
    function automatic pose_word_t random_pose();
        pose_word_t w;
        w.tag_count = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'd1;
        w.pos_x     = random_position(1'b0);
        w.pos_y     = random_position(1'b0);
        w.pos_z     = random_position(1'b0);
        w.rot_x     = random_rotation(1'b0);
        w.rot_y     = random_rotation(1'b0);
        w.rot_z     = random_rotation(1'b0);
        w.rot_w     = random_rotation(1'b0);
        w.stamp     = $urandom();
        return w;
    endfunction

    // Offers one detection word, after a random gap unless the round is steady or a burst
    // is running, and returns at the falling edge after it was accepted. s_valid is left
    // high so that a back-to-back word does not drop it; whoever pauses the input lowers it.
    task automatic send_pose(input pose_word_t w);
        int gap;
        gap = (steady || burst_left > 0) ? 0 : $urandom_range(0, 8);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        {s_tag_count, s_pos_x, s_pos_y, s_pos_z, s_rot_x, s_rot_y, s_rot_z, s_rot_w,
         s_stamp} = w;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_detection(w);
        @(negedge aclk);
    endtask

    // Writes all seven mount registers back to back. The quaternion registers only use the
    // low half of the data word, so the upper half carries random bits.
    task automatic load_mount(input quat_t qx, quat_t qy, quat_t qz, quat_t qw,
                              input pos_t ox, pos_t oy, pos_t oz);
        cfg_idx_t              idx [7];
        logic [CFG_DATA_W-1:0] val [7];
        idx = '{CFG_MOUNT_QX, CFG_MOUNT_QY, CFG_MOUNT_QZ, CFG_MOUNT_QW,
                CFG_MOUNT_OFF_X, CFG_MOUNT_OFF_Y, CFG_MOUNT_OFF_Z};
        val = '{{16'($urandom()), qx}, {16'($urandom()), qy}, {16'($urandom()), qz},
                {16'($urandom()), qw}, ox, oy, oz};
        cfg_valid = 1'b1;
        foreach (idx[i]) begin
            cfg_index = idx[i];
            cfg_data  = val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.load_register(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_valid = 1'b0;
    endtask

    // Stops the input and waits until every predicted pose has come out, then lets the
    // pipeline run empty of any dropped words before the registers may change.
    task automatic drain_poses();
        s_valid = 1'b0;
        while (sb.awaited_poses.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Result receiver: draws a stall for every word outside steady rounds, and honors a long hold-off request.
    // While waiting for a word it also notices a new hold-off request.
    initial begin : result_receiver
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid && rx_hold_cycles == 0);
        end
    end

    // Every word that leaves the block goes to the scoreboard.
    always @(posedge aclk) begin : result_monitor
        body_word_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_body_pos_x, m_body_pos_y, m_body_pos_z, m_body_rot_x, m_body_rot_y,
                   m_body_rot_z, m_body_rot_w, m_out_stamp};
            sb.check_body_pose(got);
        end
    end

    // Hang detection: any handshake on any channel restarts the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        pose_word_t pose;
        int         sent;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        {s_tag_count, s_pos_x, s_pos_y, s_pos_z, s_rot_x, s_rot_y, s_rot_z, s_rot_w,
         s_stamp} = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MOUNT_QX;
        cfg_data  = '0;
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Identity mount from reset. Counts of zero, two and the maximum are dropped.
        send_pose(make_pose(8'd0, 32'sd100, 32'sd200, 32'sd300, Q14_ONE, 16'sd0, 16'sd0,
                            16'sd0, 32'h0000_0010));
        send_pose(make_pose(8'd2, 32'sd100, 32'sd200, 32'sd300, Q14_ONE, 16'sd0, 16'sd0,
                            16'sd0, 32'h0000_0011));
        send_pose(make_pose(8'd255, POS_MOST, POS_LEAST, POS_MOST, 16'sd0, 16'sd0, 16'sd0,
                            Q14_ONE, 32'h0000_0012));
        send_pose(make_pose(8'd1, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                            32'h0000_0000));
        send_pose(make_pose(8'd1, POS_MOST, POS_LEAST, POS_MOST, Q14_ONE, Q14_NEG_ONE,
                            Q14_ONE, Q14_NEG_ONE, 32'hFFFF_FFFF));
        // Tag quaternion outside [-1, +1] passes through the product unclamped.
        send_pose(make_pose(8'd1, POS_LEAST, POS_MOST, POS_LEAST, QUAT_LEAST, QUAT_MOST,
                            -16'sd1, 16'sd0, 32'hA5A5_5A5A));
        drain_poses();

        // Half-turn-like mount with y = 0.5: two diagonal terms become one half, so odd
        // inputs land exactly on rounding halves. The x and z offsets sit at the extremes, which
        // makes the offset subtraction overflow in both directions.
        load_mount(16'sd0, 16'sd8192, 16'sd0, 16'sd0, POS_MOST, 32'sd0, POS_LEAST);
        send_pose(make_pose(8'd1, 32'sd2, 32'sd7, 32'sh8000_0003, 16'sd3, -16'sd3, 16'sd5,
                            -16'sd5, 32'h0000_0020));
        send_pose(make_pose(8'd1, POS_LEAST, -32'sd5, POS_MOST, 16'sd1, -16'sd1, 16'sd7,
                            16'sd9, 32'h0000_0021));
        send_pose(make_pose(8'd1, -32'sd1, 32'sd0, -32'sd1, -16'sd7, 16'sd9, -16'sd1,
                            16'sd1, 32'h0000_0022));
        drain_poses();

        // Mount components beyond [-1, +1] are clamped, and the resulting non-unit mount
        // drives both the quaternion and the position outputs into saturation.
        load_mount(QUAT_MOST, QUAT_LEAST, Q14_ONE, Q14_NEG_ONE, 32'sd65536, -32'sd65536,
                   32'sd1);
        send_pose(make_pose(8'd1, POS_MOST, POS_MOST, POS_MOST, Q14_ONE, Q14_ONE, Q14_ONE,
                            Q14_ONE, 32'h0000_0030));
        send_pose(make_pose(8'd1, POS_LEAST, POS_LEAST, POS_LEAST, Q14_NEG_ONE, Q14_NEG_ONE,
                            Q14_NEG_ONE, Q14_NEG_ONE, 32'h0000_0031));
        send_pose(make_pose(8'd1, 32'sd12345, -32'sd67890, 32'sd1, Q14_ONE, Q14_NEG_ONE,
                            Q14_ONE, Q14_NEG_ONE, 32'h0000_0032));
        send_pose(make_pose(8'd1, 32'sd0, 32'sd0, 32'sd0, QUAT_LEAST, QUAT_LEAST, QUAT_LEAST,
                            QUAT_LEAST, 32'h0000_0033));

        // Random rounds, each with a fresh mount. Round one uses only extreme register
        // values, round two runs without idling on either side, and round three holds the
        // receiver off while the sender keeps offering words so the pipeline backs up.
        for (int round = 0; round < ROUNDS; round++) begin
            drain_poses();
            load_mount(random_rotation(round == 1), random_rotation(round == 1),
                       random_rotation(round == 1), random_rotation(round == 1),
                       random_position(round == 1), random_position(round == 1),
                       random_position(round == 1));
            steady = (round == 2);
            if (round == 3) begin
                rx_hold_cycles = HOLD_OFF_CYCLES;
                burst_left     = BURST_WORDS;
            end
            sent = 0;
            while (sent < POSES_PER_ROUND) begin
                pose = random_pose();
                send_pose(pose);
                if (pose.tag_count == 8'd1) begin
                    sent++;
                end
            end
        end

        drain_poses();
        if (sb.failures == 0 && sb.awaited_poses.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
